// ----- rtl/core/isbc_pkg.sv -----
package isbc_pkg;

    // Fixed field widths
    localparam int BIAS_W    = 16;
    localparam int WINDOW_W  = 13;
    localparam int PCT_W     = 7;
    localparam int NUM_AXES  = 4;

    // Constants of the algorithm
    localparam int                  AZ_OFFSET    = 16384;
    localparam logic [PCT_W-1:0]    PCT_FULL     = 7'd100;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 13'd256;

    // Axis order in the bias and sum stores
    localparam logic [1:0] AX_AZ   = 2'd0;
    localparam logic [1:0] AX_GX   = 2'd1;
    localparam logic [1:0] AX_GY   = 2'd2;
    localparam logic [1:0] AX_GZ   = 2'd3;

    // Event codes on the func field
    typedef enum logic [2:0] {
        FN_SAMPLE       = 3'd0,
        FN_LOAD         = 3'd1,
        FN_RESTART      = 3'd2,
        FN_CLEAR        = 3'd3,
        FN_TAKE_DIRTY   = 3'd4,
        FN_PERSISTED    = 3'd5,
        FN_PERSIST_FAIL = 3'd6
    } func_t;

    // Resolved calibration state codes
    typedef enum logic [2:0] {
        CS_IDLE       = 3'd0,
        CS_REQUIRED   = 3'd1,
        CS_COLLECTING = 3'd2,
        CS_SOLVED     = 3'd3,
        CS_PERSISTING = 3'd4,
        CS_FAILED     = 3'd5,
        CS_VALID      = 3'd6
    } cal_state_t;

    typedef struct packed {
        logic failed;
        logic persisting;
        logic dirty;
        logic pending;
        logic calibrated;
    } flags_t;

    // One result record as presented on the output channel
    typedef struct packed {
        logic [2:0]              cal_state;
        logic                    is_calibrated;
        logic                    is_pending;
        logic                    is_dirty;
        logic [PCT_W-1:0]        progress_pct;
        logic                    took_dirty;
        logic                    out_valid;
        logic signed [BIAS_W-1:0] bias_az;
        logic signed [BIAS_W-1:0] bias_gx;
        logic signed [BIAS_W-1:0] bias_gy;
        logic signed [BIAS_W-1:0] bias_gz;
    } result_t;

    // Priority resolution of the flags into a state code
    function automatic cal_state_t state_code(input flags_t fl, input logic count_zero);
        cal_state_t code;
        if (fl.persisting)      code = CS_PERSISTING;
        else if (fl.failed)     code = CS_FAILED;
        else if (fl.dirty)      code = CS_SOLVED;
        else if (fl.pending)    code = count_zero ? CS_REQUIRED : CS_COLLECTING;
        else if (fl.calibrated) code = CS_VALID;
        else                    code = CS_IDLE;
        return code;
    endfunction

endpackage

// ----- rtl/core/isbc_if.sv -----
// Input event channel
interface isbc_in_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          func;
    logic                                at_rest;
    logic                                load_valid;
    logic signed [isbc_pkg::BIAS_W-1:0]  az;
    logic signed [isbc_pkg::BIAS_W-1:0]  gx;
    logic signed [isbc_pkg::BIAS_W-1:0]  gy;
    logic signed [isbc_pkg::BIAS_W-1:0]  gz;

    modport source (
        output valid, func, at_rest, load_valid, az, gx, gy, gz,
        input  ready
    );
    modport sink (
        input  valid, func, at_rest, load_valid, az, gx, gy, gz,
        output ready
    );
endinterface

// Result channel
interface isbc_out_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          cal_state;
    logic                                is_calibrated;
    logic                                is_pending;
    logic                                is_dirty;
    logic [isbc_pkg::PCT_W-1:0]          progress_pct;
    logic                                took_dirty;
    logic                                out_valid;
    logic signed [isbc_pkg::BIAS_W-1:0]  bias_az;
    logic signed [isbc_pkg::BIAS_W-1:0]  bias_gx;
    logic signed [isbc_pkg::BIAS_W-1:0]  bias_gy;
    logic signed [isbc_pkg::BIAS_W-1:0]  bias_gz;

    modport source (
        output valid, cal_state, is_calibrated, is_pending, is_dirty, progress_pct,
               took_dirty, out_valid, bias_az, bias_gx, bias_gy, bias_gz,
        input  ready
    );
    modport sink (
        input  valid, cal_state, is_calibrated, is_pending, is_dirty, progress_pct,
               took_dirty, out_valid, bias_az, bias_gx, bias_gy, bias_gz,
        output ready
    );
endinterface

// ----- rtl/core/isbc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Keeps only the low BIAS_W quotient bits; done pulses when quot is valid.
module isbc_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_W-1:0]             num,
    input  logic [DEN_W-1:0]             den,
    output logic                         done,
    output logic [isbc_pkg::BIAS_W-1:0]  quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [NUM_W-1:0]              num_reg, num_next;
    logic [DEN_W-1:0]              den_reg, den_next;
    logic [DEN_W-1:0]              rem_reg, rem_next;
    logic [isbc_pkg::BIAS_W-1:0]   quot_reg, quot_next;

    logic [DEN_W:0]                trial;
    logic [DEN_W+1:0]              diff;
    logic                          ge;

    // One trial subtraction
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign ge    = ~diff[DEN_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_next = {quot_reg[isbc_pkg::BIAS_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/core/imu_static_bias_calibrator.sv -----
// Non-sample events and ignored samples go straight to S_EMIT, which loads the result once the output is free.
// A still sample short of the window runs one progress division of 16+ceil(log2(MAX_WINDOW+1))
// divider steps: 29 steps at MAX_WINDOW=4096. A sample that fills the window runs
// four bias divisions, one per axis, on the shared divider.
// One event at a time; ready is low until the result is loaded.
// Reset (rst_n, async low): flags, window, sums and biases clear, window_len returns to 256.
module imu_static_bias_calibrator #(
    parameter int MAX_WINDOW = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    isbc_in_if.sink                           sample_ch,
    isbc_out_if.source                        result_ch,
    input  logic                              cfg_we,
    input  logic [isbc_pkg::WINDOW_W-1:0]     cfg_wdata
);

    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = 17 + CW;
    localparam int MAG_W = 16 + CW;
    localparam int BW    = isbc_pkg::BIAS_W;
    localparam logic [1:0] LAST_AXIS = 2'(isbc_pkg::NUM_AXES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROG,
        S_SOLVE,
        S_EMIT
    } seq_state_t;

    seq_state_t                   state_reg, state_next;
    logic [1:0]                   axis_reg, axis_next;
    logic                         launch_reg, launch_next;
    logic [isbc_pkg::WINDOW_W-1:0] wl_reg, wl_next;
    logic [CW-1:0]                count_reg, count_next;
    logic signed [SUM_W-1:0]      sum_reg [isbc_pkg::NUM_AXES];
    logic signed [SUM_W-1:0]      sum_next [isbc_pkg::NUM_AXES];
    logic signed [BW-1:0]         bias_reg [isbc_pkg::NUM_AXES];
    logic signed [BW-1:0]         bias_next [isbc_pkg::NUM_AXES];
    logic [isbc_pkg::PCT_W-1:0]   progress_reg, progress_next;
    isbc_pkg::flags_t             flags_reg, flags_next;
    logic                         took_reg, took_next;
    logic                         ovalid_reg, ovalid_next;
    logic                         out_valid_reg, out_valid_next;
    isbc_pkg::result_t            out_reg;
    isbc_pkg::result_t            rec;

    logic                         in_fire;
    logic                         out_load;
    logic                         clear_win;
    logic [CW-1:0]                w_eff;
    logic [CW-1:0]                count_inc;
    logic signed [SUM_W-1:0]      sel_sum;
    logic                         sum_neg;
    logic [SUM_W-1:0]             sum_abs;
    logic [MAG_W-1:0]             pct_num;
    logic [MAG_W-1:0]             div_num;
    logic [CW-1:0]                div_den;
    logic                         div_done;
    logic [BW-1:0]                div_quot;
    logic signed [BW-1:0]         bias_q;

    // Effective window: zero acts as one, clamp to MAX_WINDOW
    always_comb
    begin
        if (wl_reg == '0)
            w_eff = CW'(1);
        else if (32'(wl_reg) > MAX_WINDOW)
            w_eff = CW'(MAX_WINDOW);
        else
            w_eff = CW'(wl_reg);
    end

    assign count_inc = (count_reg < w_eff) ? count_reg + CW'(1) : count_reg;

    // Divider operands: bias magnitude of the current axis, or count*100 over window
    assign sel_sum  = sum_reg[axis_reg];
    assign sum_neg  = sel_sum[SUM_W-1];
    assign sum_abs  = sum_neg ? -sel_sum : sel_sum;
    assign pct_num  = MAG_W'(count_reg) * MAG_W'(isbc_pkg::PCT_FULL);
    assign div_num  = (state_reg == S_SOLVE) ? sum_abs[MAG_W-1:0] : pct_num;
    assign div_den  = (state_reg == S_SOLVE) ? count_reg : w_eff;
    assign bias_q   = sum_neg ? $signed(-div_quot) : $signed(div_quot);

    isbc_div #(
        .NUM_W (MAG_W),
        .DEN_W (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (launch_reg),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign sample_ch.ready = (state_reg == S_IDLE);
    assign in_fire         = sample_ch.valid && sample_ch.ready;

    // Sequencer and event handling
    always_comb
    begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        launch_next   = 1'b0;
        wl_next       = cfg_we ? cfg_wdata : wl_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        bias_next     = bias_reg;
        progress_next = progress_reg;
        flags_next    = flags_reg;
        took_next     = took_reg;
        ovalid_next   = ovalid_reg;
        out_load      = 1'b0;
        clear_win     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    took_next   = 1'b0;
                    ovalid_next = 1'b0;
                    state_next  = S_EMIT;
                    unique case (sample_ch.func)
                        isbc_pkg::FN_SAMPLE:
                        begin
                            if (flags_reg.pending)
                            begin
                                if (!sample_ch.at_rest)
                                    clear_win = 1'b1;
                                else
                                begin
                                    sum_next[isbc_pkg::AX_AZ] = sum_reg[isbc_pkg::AX_AZ]
                                        + SUM_W'(sample_ch.az) - SUM_W'(isbc_pkg::AZ_OFFSET);
                                    sum_next[isbc_pkg::AX_GX] = sum_reg[isbc_pkg::AX_GX]
                                        + SUM_W'(sample_ch.gx);
                                    sum_next[isbc_pkg::AX_GY] = sum_reg[isbc_pkg::AX_GY]
                                        + SUM_W'(sample_ch.gy);
                                    sum_next[isbc_pkg::AX_GZ] = sum_reg[isbc_pkg::AX_GZ]
                                        + SUM_W'(sample_ch.gz);
                                    count_next  = count_inc;
                                    launch_next = 1'b1;
                                    axis_next   = isbc_pkg::AX_AZ;
                                    state_next  = (count_inc >= w_eff) ? S_SOLVE : S_PROG;
                                end
                            end
                        end
                        isbc_pkg::FN_LOAD:
                        begin
                            flags_next.persisting = 1'b0;
                            flags_next.failed     = 1'b0;
                            if (!sample_ch.load_valid)
                            begin
                                flags_next.calibrated = 1'b0;
                                flags_next.dirty      = 1'b0;
                                flags_next.pending    = 1'b1;
                                clear_win             = 1'b1;
                            end
                            else
                            begin
                                bias_next[isbc_pkg::AX_AZ] = sample_ch.az;
                                bias_next[isbc_pkg::AX_GX] = sample_ch.gx;
                                bias_next[isbc_pkg::AX_GY] = sample_ch.gy;
                                bias_next[isbc_pkg::AX_GZ] = sample_ch.gz;
                                flags_next.calibrated = 1'b1;
                                flags_next.pending    = 1'b0;
                                flags_next.dirty      = 1'b0;
                                progress_next         = isbc_pkg::PCT_FULL;
                            end
                        end
                        isbc_pkg::FN_RESTART:
                        begin
                            flags_next         = '0;
                            flags_next.pending = 1'b1;
                            clear_win          = 1'b1;
                        end
                        isbc_pkg::FN_CLEAR:
                        begin
                            for (int i = 0; i < isbc_pkg::NUM_AXES; i++)
                                bias_next[i] = '0;
                            flags_next            = '0;
                            flags_next.failed     = flags_reg.failed;
                            flags_next.pending    = 1'b1;
                            clear_win             = 1'b1;
                        end
                        isbc_pkg::FN_TAKE_DIRTY:
                        begin
                            if (flags_reg.dirty)
                            begin
                                took_next             = 1'b1;
                                ovalid_next           = flags_reg.calibrated;
                                flags_next.persisting = 1'b1;
                                flags_next.failed     = 1'b0;
                                flags_next.dirty      = 1'b0;
                            end
                        end
                        isbc_pkg::FN_PERSISTED:
                        begin
                            flags_next.persisting = 1'b0;
                            flags_next.failed     = 1'b0;
                        end
                        isbc_pkg::FN_PERSIST_FAIL:
                        begin
                            if (flags_reg.persisting)
                            begin
                                flags_next.persisting = 1'b0;
                                flags_next.failed     = 1'b1;
                                flags_next.dirty      = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused code: status report only
                        end
                    endcase
                end
            end
            S_PROG:
            begin
                if (div_done)
                begin
                    progress_next = div_quot[isbc_pkg::PCT_W-1:0];
                    state_next    = S_EMIT;
                end
            end
            S_SOLVE:
            begin
                if (div_done)
                begin
                    bias_next[axis_reg] = bias_q;
                    if (axis_reg == LAST_AXIS)
                    begin
                        flags_next            = '0;
                        flags_next.calibrated = 1'b1;
                        flags_next.dirty      = 1'b1;
                        progress_next         = isbc_pkg::PCT_FULL;
                        state_next            = S_EMIT;
                    end
                    else
                    begin
                        axis_next   = axis_reg + 2'd1;
                        launch_next = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Window reset
        if (clear_win)
        begin
            count_next    = '0;
            progress_next = '0;
            for (int i = 0; i < isbc_pkg::NUM_AXES; i++)
                sum_next[i] = '0;
        end

        // Output register valid
        if (out_load)
            out_valid_next = 1'b1;
        else if (result_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Result record from current state
    always_comb
    begin
        rec.cal_state     = isbc_pkg::state_code(flags_reg, count_reg == '0);
        rec.is_calibrated = flags_reg.calibrated;
        rec.is_pending    = flags_reg.pending;
        rec.is_dirty      = flags_reg.dirty;
        rec.progress_pct  = progress_reg;
        rec.took_dirty    = took_reg;
        rec.out_valid     = ovalid_reg;
        rec.bias_az       = bias_reg[isbc_pkg::AX_AZ];
        rec.bias_gx       = bias_reg[isbc_pkg::AX_GX];
        rec.bias_gy       = bias_reg[isbc_pkg::AX_GY];
        rec.bias_gz       = bias_reg[isbc_pkg::AX_GZ];
    end

    // State, calibration store and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= isbc_pkg::AX_AZ;
            launch_reg    <= 1'b0;
            wl_reg        <= isbc_pkg::WINDOW_RESET;
            count_reg     <= '0;
            sum_reg       <= '{default: '0};
            bias_reg      <= '{default: '0};
            progress_reg  <= '0;
            flags_reg     <= '0;
            took_reg      <= 1'b0;
            ovalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            launch_reg    <= launch_next;
            wl_reg        <= wl_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            bias_reg      <= bias_next;
            progress_reg  <= progress_next;
            flags_reg     <= flags_next;
            took_reg      <= took_next;
            ovalid_reg    <= ovalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= rec;
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.cal_state     = out_reg.cal_state;
    assign result_ch.is_calibrated = out_reg.is_calibrated;
    assign result_ch.is_pending    = out_reg.is_pending;
    assign result_ch.is_dirty      = out_reg.is_dirty;
    assign result_ch.progress_pct  = out_reg.progress_pct;
    assign result_ch.took_dirty    = out_reg.took_dirty;
    assign result_ch.out_valid     = out_reg.out_valid;
    assign result_ch.bias_az       = out_reg.bias_az;
    assign result_ch.bias_gx       = out_reg.bias_gx;
    assign result_ch.bias_gy       = out_reg.bias_gy;
    assign result_ch.bias_gz       = out_reg.bias_gz;

    // Divider only finishes inside a division sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_PROG || state_reg == S_SOLVE))
        else $error("divider finished outside a division sequence");

    // Window count never passes the largest window
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_WINDOW)
        else $error("sample count beyond MAX_WINDOW");

    // Reported progress stays within percent range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> result_ch.progress_pct <= isbc_pkg::PCT_FULL)
        else $error("progress above 100 percent");

    // A hand-out always reports the persisting state
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.took_dirty) |->
            (result_ch.cal_state == isbc_pkg::CS_PERSISTING && !result_ch.is_dirty))
        else $error("took_dirty without persisting state");

endmodule
